[rtl/core/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants for the k-way merge core.
// ----------------------------------------------------------------------------
package kwm_pkg;

   localparam int LANE_W            = 3;
   localparam int DATA_W            = 32;
   localparam int NUM_LANES_DEF     = 8;
   localparam int VALUE_WIDTH_DEF   = 32;

   typedef struct packed {
      logic [LANE_W-1:0]        lane;
      logic signed [DATA_W-1:0] value;
      logic                     lane_empty;
   } kwm_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value_res;
      logic [LANE_W-1:0]        source_lane;
      logic                     merge_done;
   } kwm_rsp_type;

   // lane store update controls
   typedef struct packed {
      logic upd;      // a word is being applied to the heads
      logic pop_en;   // the selected head is emitted
      logic clear;    // merge finished, drop all flags
   } kwm_ctl_type;

endpackage

[rtl/core/kwm_lane_store.sv]
// ----------------------------------------------------------------------------
// kwm_lane_store
// Per-lane head registers with valid and exhausted flags. Presents the view
// of the heads with the current word already applied.
// ----------------------------------------------------------------------------
module kwm_lane_store
   import kwm_pkg::*;
#(
   parameter int NUM_LANES   = NUM_LANES_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int IDX_W       = $clog2(NUM_LANES)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kwm_req_type                   item,
   input  kwm_ctl_type                   ctl,
   input  logic [IDX_W-1:0]              pop_idx,
   output logic [NUM_LANES-1:0]          view_valid,
   output logic [NUM_LANES-1:0]          view_exh,
   output logic signed [VALUE_WIDTH-1:0] view_head [NUM_LANES],
   output logic [NUM_LANES-1:0]          valid_q,
   output logic [NUM_LANES-1:0]          exh_q
);

   logic signed [VALUE_WIDTH-1:0] head_ff [NUM_LANES];
   logic [NUM_LANES-1:0]          valid_ff;
   logic [NUM_LANES-1:0]          exh_ff;
   logic [NUM_LANES-1:0]          valid_in;
   logic [NUM_LANES-1:0]          exh_in;
   logic signed [VALUE_WIDTH-1:0] fit_value;

   generate
      if (VALUE_WIDTH <= DATA_W) begin : g_trunc
         assign fit_value = item.value[VALUE_WIDTH-1:0];
      end else begin : g_sext
         assign fit_value = {{(VALUE_WIDTH-DATA_W){item.value[DATA_W-1]}}, item.value};
      end
   endgenerate

   genvar j;
   generate
      for (j = 0; j < NUM_LANES; j++) begin : g_lane
         logic hit;
         logic load;

         // lanes beyond the lane field never match
         assign hit  = ctl.upd && (32'(item.lane) == 32'(j));
         assign load = hit && !item.lane_empty && !valid_ff[j] && !exh_ff[j];

         assign view_valid[j] = valid_ff[j] | load;
         assign view_exh[j]   = exh_ff[j] | (hit & item.lane_empty);
         assign view_head[j]  = load ? fit_value : head_ff[j];

         assign valid_in[j] = !ctl.clear && view_valid[j] &&
                              !(ctl.pop_en && (pop_idx == IDX_W'(j)));
         assign exh_in[j]   = !ctl.clear && view_exh[j];

         always_ff @(posedge clock) begin
            head_ff[j] <= view_head[j];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         exh_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         exh_ff   <= exh_in;
      end
   end

   assign valid_q = valid_ff;
   assign exh_q   = exh_ff;

endmodule

[rtl/core/kwm_min_tree.sv]
// ----------------------------------------------------------------------------
// kwm_min_tree
// Comparison tree picking the smallest valid head; ties go to the lower lane.
// ----------------------------------------------------------------------------
module kwm_min_tree
   import kwm_pkg::*;
#(
   parameter int NUM_LANES   = NUM_LANES_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int IDX_W       = $clog2(NUM_LANES)
) (
   input  logic [NUM_LANES-1:0]          head_valid,
   input  logic signed [VALUE_WIDTH-1:0] head_value [NUM_LANES],
   output logic                          found,
   output logic [IDX_W-1:0]              best_idx,
   output logic signed [VALUE_WIDTH-1:0] best_value
);

   localparam int LEAVES = 1 << IDX_W;
   localparam int NODES  = 2 * LEAVES - 1;

   // heap layout: node k has children 2k+1 and 2k+2, leaves start at LEAVES-1
   logic                          node_v   [NODES];
   logic signed [VALUE_WIDTH-1:0] node_val [NODES];
   logic [IDX_W-1:0]              node_idx [NODES];

   genvar i, k;
   generate
      for (i = 0; i < LEAVES; i++) begin : g_leaf
         if (i < NUM_LANES) begin : g_real
            assign node_v[LEAVES-1+i]   = head_valid[i];
            assign node_val[LEAVES-1+i] = head_value[i];
         end else begin : g_pad
            assign node_v[LEAVES-1+i]   = 1'b0;
            assign node_val[LEAVES-1+i] = '0;
         end
         assign node_idx[LEAVES-1+i] = IDX_W'(i);
      end

      for (k = 0; k < LEAVES - 1; k++) begin : g_node
         logic take_left;
         assign take_left = node_v[2*k+1] &&
                            (!node_v[2*k+2] || !(node_val[2*k+2] < node_val[2*k+1]));
         assign node_v[k]   = node_v[2*k+1] | node_v[2*k+2];
         assign node_val[k] = take_left ? node_val[2*k+1] : node_val[2*k+2];
         assign node_idx[k] = take_left ? node_idx[2*k+1] : node_idx[2*k+2];
      end
   endgenerate

   assign found      = node_v[0];
   assign best_idx   = node_idx[0];
   assign best_value = node_val[0];

endmodule

[rtl/core/k_way_merge_core.sv]
// A word waits in the input register until the result register is free or draining.
// Throughput: one word per cycle while the result register is free or draining; the lane
// update and the min tree over all heads settle between the input and result registers.
// Reset: synchronous, clears the valid and exhausted flags and both handshake stages;
// head values are not reset and are written before they are read.
// ----------------------------------------------------------------------------
// k_way_merge_core
// Merges ascending lane streams into one ascending stream of words.
// ----------------------------------------------------------------------------
module k_way_merge_core
   import kwm_pkg::*;
#(
   parameter int NUM_LANES   = NUM_LANES_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  kwm_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output kwm_rsp_type rsp_data
);

   localparam int IDX_W = $clog2(NUM_LANES);

   kwm_req_type                   in_ff;
   logic                          in_valid_ff;
   logic                          in_valid_in;
   kwm_rsp_type                   rsp_ff;
   kwm_rsp_type                   rsp_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          stage_fire;
   logic                          all_ready;
   logic                          emit;
   kwm_ctl_type                   ctl;
   logic [NUM_LANES-1:0]          view_valid;
   logic [NUM_LANES-1:0]          view_exh;
   logic signed [VALUE_WIDTH-1:0] view_head [NUM_LANES];
   logic [NUM_LANES-1:0]          valid_q;
   logic [NUM_LANES-1:0]          exh_q;
   logic                          found;
   logic [IDX_W-1:0]              best_idx;
   logic signed [VALUE_WIDTH-1:0] best_value;
   logic signed [DATA_W-1:0]      out_value;
   logic [LANE_W-1:0]             out_lane;

   assign stage_fire = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || stage_fire;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (stage_fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   kwm_lane_store #(
      .NUM_LANES   (NUM_LANES),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX_W       (IDX_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .item       (in_ff),
      .ctl        (ctl),
      .pop_idx    (best_idx),
      .view_valid (view_valid),
      .view_exh   (view_exh),
      .view_head  (view_head),
      .valid_q    (valid_q),
      .exh_q      (exh_q)
   );

   kwm_min_tree #(
      .NUM_LANES   (NUM_LANES),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX_W       (IDX_W)
   ) u_tree (
      .head_valid (view_valid),
      .head_value (view_head),
      .found      (found),
      .best_idx   (best_idx),
      .best_value (best_value)
   );

   // every lane holds a head or is exhausted
   assign all_ready = &(view_valid | view_exh);
   assign emit      = stage_fire && all_ready;

   always_comb begin
      ctl.upd    = stage_fire;
      ctl.pop_en = emit && found;
      ctl.clear  = emit && !found;
   end

   generate
      if (VALUE_WIDTH >= DATA_W) begin : g_out_trunc
         assign out_value = best_value[DATA_W-1:0];
      end else begin : g_out_sext
         assign out_value = {{(DATA_W-VALUE_WIDTH){best_value[VALUE_WIDTH-1]}}, best_value};
      end
      if (IDX_W >= LANE_W) begin : g_lane_trunc
         assign out_lane = best_idx[LANE_W-1:0];
      end else begin : g_lane_ext
         assign out_lane = {{(LANE_W-IDX_W){1'b0}}, best_idx};
      end
   endgenerate

   always_comb begin
      if (found) begin
         rsp_in.value_res   = out_value;
         rsp_in.source_lane = out_lane;
         rsp_in.merge_done  = 1'b0;
      end else begin
         rsp_in.value_res   = '0;
         rsp_in.source_lane = '0;
         rsp_in.merge_done  = 1'b1;
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // emitted head is released
   a_pop_clears: assert property (@(posedge clock) disable iff (reset)
      (emit && found) |=> !valid_q[$past(best_idx)])
      else $error("popped lane still holds a head");

   // finished merge drops every flag
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (emit && !found) |=> (valid_q == '0 && exh_q == '0))
      else $error("flags not cleared after merge done");

   // done only when every lane is exhausted
   a_done_exh: assert property (@(posedge clock) disable iff (reset)
      (emit && !found) |-> (&view_exh))
      else $error("merge done with a lane still open");

   // a new result only lands in a free or draining output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");
`endif

endmodule
